// File: rtl/tcsb_pkg.sv
// Shared types and constants for the text console screen buffer.
// Depends on nothing; every other file but tcsb_ram imports it.
package tcsb_pkg;

   // Default screen geometry and tab spacing.
   localparam int COLUMNS_DEFAULT  = 80;
   localparam int ROWS_DEFAULT     = 25;
   localparam int TAB_STOP_DEFAULT = 8;

   // Fixed field widths.
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;

   // Control bytes and reset values.
   localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0d;
   localparam logic [CHAR_W-1:0] CODE_LF    = 8'h0a;
   localparam logic [CHAR_W-1:0] CODE_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CODE_SPACE = 8'h20;
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

   // Operation codes of an input word.
   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [CHAR_W-1:0] char_code;
      logic [ROW_W-1:0]  read_row;
      logic [COL_W-1:0]  read_col;
   } req_item_type;

   typedef struct packed {
      logic [CHAR_W-1:0] cell_char;
      logic [ATTR_W-1:0] cell_attr;
      logic [COL_W-1:0]  cursor_col;
      logic [ROW_W-1:0]  cursor_row;
   } rsp_item_type;

   // Command classes handed from the front to the back.
   typedef enum logic [2:0] {
      CMD_PUT,
      CMD_CR,
      CMD_LF,
      CMD_TAB,
      CMD_READ,
      CMD_READ_OUT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [CHAR_W-1:0] char_code;
      logic [ROW_W-1:0]  read_row;
      logic [COL_W-1:0]  read_col;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_READ,
      BK_COPY,
      BK_BLANK
   } back_state_type;

endpackage

// File: rtl/tcsb_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module tcsb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/tcsb_front.sv
// Front end: accepts request words, classifies them and holds one command
// until the queue takes it. Depends on tcsb_pkg.
module tcsb_front #(
   parameter int COLUMNS = tcsb_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcsb_pkg::ROWS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  tcsb_pkg::req_item_type req_item,
   input  logic                   hold_off,
   input  logic                   q_full,
   output logic                   push,
   output tcsb_pkg::cmd_type      cmd,
   output logic                   stage_valid
);
   import tcsb_pkg::*;

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;

   assign busy   = hold_off || (valid_ff && q_full);
   assign accept = start && !busy;
   assign push   = valid_ff && !q_full;

   always_comb begin
      cmd_in.char_code = req_item.char_code;
      cmd_in.read_row  = req_item.read_row;
      cmd_in.read_col  = req_item.read_col;
      if (req_item.operation == OP_READ) begin
         if ((req_item.read_row < ROWS) && (req_item.read_col < COLUMNS)) begin
            cmd_in.kind = CMD_READ;
         end else begin
            cmd_in.kind = CMD_READ_OUT;
         end
      end else begin
         unique case (req_item.char_code)
            CODE_CR:  cmd_in.kind = CMD_CR;
            CODE_LF:  cmd_in.kind = CMD_LF;
            CODE_TAB: cmd_in.kind = CMD_TAB;
            default:  cmd_in.kind = CMD_PUT;
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd         = cmd_ff;
   assign stage_valid = valid_ff;

endmodule

// File: rtl/tcsb_queue.sv
// Two-entry command queue between front and back.
// Depends on tcsb_pkg.
module tcsb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tcsb_pkg::cmd_type push_cmd,
   input  logic              pop,
   output tcsb_pkg::cmd_type head,
   output logic              full,
   output logic              empty
);
   import tcsb_pkg::*;

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/tcsb_back.sv
// Back end: owns the cursor and the character/attribute stores, executes
// commands, scrolls and produces result words. Depends on tcsb_pkg, tcsb_ram.
module tcsb_back #(
   parameter int COLUMNS  = tcsb_pkg::COLUMNS_DEFAULT,
   parameter int ROWS     = tcsb_pkg::ROWS_DEFAULT,
   parameter int TAB_STOP = tcsb_pkg::TAB_STOP_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  tcsb_pkg::cmd_type             q_head,
   output logic                          q_pop,
   input  logic [tcsb_pkg::ATTR_W-1:0]   char_attr,
   output logic                          rsp_strobe,
   output tcsb_pkg::rsp_item_type        rsp_item,
   output logic                          clearing
);
   import tcsb_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int XW    = CW + 2;
   localparam int SW    = RW + 2;

   localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
   localparam logic [AW-1:0] COPY_FIRST  = AW'(COLUMNS);
   localparam logic [AW-1:0] BOTTOM_BASE = AW'((ROWS - 1) * COLUMNS);
   localparam logic [XW-1:0] ONE_WIDTH   = XW'(COLUMNS);
   localparam logic [XW-1:0] TWO_WIDTH   = XW'(2 * COLUMNS);
   localparam logic [SW-1:0] ROWS_X      = SW'(ROWS);
   localparam logic [SW-1:0] LAST_ROW_X  = SW'(ROWS - 1);

   back_state_type state_ff, state_in;
   logic [AW-1:0]  cnt_ff, cnt_in;
   logic           wr_pend_ff, wr_pend_in;
   logic [AW-1:0]  wr_addr_ff, wr_addr_in;
   logic [1:0]     scroll_ff, scroll_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic           rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type   rsp_item_ff, rsp_item_in;

   logic              ch_we, at_we;
   logic [AW-1:0]     waddr, raddr;
   logic [CHAR_W-1:0] ch_wdata, ch_rdata;
   logic [ATTR_W-1:0] at_wdata, at_rdata;

   logic [AW-1:0] cur_addr, rd_addr;

   // Tab targets per column, worked out at elaboration.
   logic [XW-1:0] tab_tbl [COLUMNS];
   for (genvar g = 0; g < COLUMNS; g++) begin : g_tab
      assign tab_tbl[g] = XW'(((g + 1) / TAB_STOP + 1) * TAB_STOP);
   end

   // Cursor move for a put, CR, LF or TAB command.
   logic [XW-1:0] x_base, x_fit;
   logic [1:0]    add_rows, wraps;
   logic [SW-1:0] row_sum;
   logic [CW-1:0] next_col;
   logic [RW-1:0] next_row;
   logic [1:0]    next_scroll;

   assign cur_addr = AW'(32'(row_ff) * 32'(COLUMNS) + 32'(col_ff));
   assign rd_addr  = AW'(32'(q_head.read_row) * 32'(COLUMNS) + 32'(q_head.read_col));

   always_comb begin
      add_rows = 2'd0;
      unique case (q_head.kind) inside
         CMD_PUT: x_base = XW'(col_ff) + XW'(1);
         CMD_TAB: x_base = tab_tbl[col_ff];
         CMD_LF: begin
            x_base   = '0;
            add_rows = 2'd1;
         end
         default: x_base = '0;
      endcase
      if (x_base >= TWO_WIDTH) begin
         x_fit = x_base - TWO_WIDTH;
         wraps = 2'd2;
      end else if (x_base >= ONE_WIDTH) begin
         x_fit = x_base - ONE_WIDTH;
         wraps = 2'd1;
      end else begin
         x_fit = x_base;
         wraps = 2'd0;
      end
      next_col = CW'(x_fit);
      row_sum  = SW'(row_ff) + SW'(add_rows) + SW'(wraps);
      if (row_sum >= ROWS_X) begin
         next_row    = RW'(LAST_ROW_X);
         next_scroll = 2'(row_sum - LAST_ROW_X);
      end else begin
         next_row    = RW'(row_sum);
         next_scroll = 2'd0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      wr_pend_in    = 1'b0;
      wr_addr_in    = wr_addr_ff;
      scroll_in     = scroll_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      q_pop         = 1'b0;
      ch_we         = 1'b0;
      at_we         = 1'b0;
      waddr         = cur_addr;
      ch_wdata      = q_head.char_code;
      at_wdata      = char_attr;
      raddr         = rd_addr;

      unique case (state_ff)
         BK_CLEAR: begin
            ch_we    = 1'b1;
            at_we    = 1'b1;
            waddr    = cnt_ff;
            ch_wdata = CODE_SPACE;
            at_wdata = '0;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = BK_IDLE;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end

         BK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               unique case (q_head.kind) inside
                  CMD_READ: begin
                     state_in = BK_READ;
                  end
                  CMD_READ_OUT: begin
                     rsp_strobe_in          = 1'b1;
                     rsp_item_in.cell_char  = '0;
                     rsp_item_in.cell_attr  = '0;
                     rsp_item_in.cursor_col = COL_W'(col_ff);
                     rsp_item_in.cursor_row = ROW_W'(row_ff);
                  end
                  CMD_PUT, CMD_CR, CMD_LF, CMD_TAB: begin
                     if (q_head.kind == CMD_PUT) begin
                        ch_we = 1'b1;
                        at_we = 1'b1;
                     end
                     col_in = next_col;
                     row_in = next_row;
                     if (next_scroll != 2'd0) begin
                        scroll_in = next_scroll;
                        cnt_in    = COPY_FIRST;
                        state_in  = BK_COPY;
                     end else begin
                        rsp_strobe_in          = 1'b1;
                        rsp_item_in.cell_char  = '0;
                        rsp_item_in.cell_attr  = '0;
                        rsp_item_in.cursor_col = COL_W'(next_col);
                        rsp_item_in.cursor_row = ROW_W'(next_row);
                     end
                  end
                  default: begin
                     state_in = BK_IDLE;
                  end
               endcase
            end
         end

         BK_READ: begin
            rsp_strobe_in          = 1'b1;
            rsp_item_in.cell_char  = ch_rdata;
            rsp_item_in.cell_attr  = at_rdata;
            rsp_item_in.cursor_col = COL_W'(col_ff);
            rsp_item_in.cursor_row = ROW_W'(row_ff);
            state_in               = BK_IDLE;
         end

         BK_COPY: begin
            // Read one row ahead, write the word read last cycle.
            raddr      = cnt_ff;
            wr_pend_in = 1'b1;
            wr_addr_in = cnt_ff - COPY_FIRST;
            if (wr_pend_ff) begin
               ch_we    = 1'b1;
               at_we    = 1'b1;
               waddr    = wr_addr_ff;
               ch_wdata = ch_rdata;
               at_wdata = at_rdata;
            end
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = BOTTOM_BASE;
               state_in = BK_BLANK;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end

         BK_BLANK: begin
            if (wr_pend_ff) begin
               // Drain the last copy write first.
               ch_we    = 1'b1;
               at_we    = 1'b1;
               waddr    = wr_addr_ff;
               ch_wdata = ch_rdata;
               at_wdata = at_rdata;
            end else begin
               ch_we    = 1'b1;
               waddr    = cnt_ff;
               ch_wdata = CODE_SPACE;
               if (cnt_ff == LAST_CELL) begin
                  if (scroll_ff == 2'd1) begin
                     scroll_in              = 2'd0;
                     rsp_strobe_in          = 1'b1;
                     rsp_item_in.cell_char  = '0;
                     rsp_item_in.cell_attr  = '0;
                     rsp_item_in.cursor_col = COL_W'(col_ff);
                     rsp_item_in.cursor_row = ROW_W'(row_ff);
                     state_in               = BK_IDLE;
                  end else begin
                     scroll_in = scroll_ff - 2'd1;
                     cnt_in    = COPY_FIRST;
                     state_in  = BK_COPY;
                  end
               end else begin
                  cnt_in = cnt_ff + AW'(1);
               end
            end
         end

         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_CLEAR;
         cnt_ff        <= '0;
         wr_pend_ff    <= 1'b0;
         scroll_ff     <= 2'd0;
         col_ff        <= '0;
         row_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         wr_pend_ff    <= wr_pend_in;
         scroll_ff     <= scroll_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff  <= wr_addr_in;
      rsp_item_ff <= rsp_item_in;
   end

   tcsb_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (CELLS)
   ) u_char_ram (
      .clock (clock),
      .we    (ch_we),
      .waddr (waddr),
      .wdata (ch_wdata),
      .raddr (raddr),
      .rdata (ch_rdata)
   );

   tcsb_ram #(
      .WIDTH (ATTR_W),
      .DEPTH (CELLS)
   ) u_attr_ram (
      .clock (clock),
      .we    (at_we),
      .waddr (waddr),
      .wdata (at_wdata),
      .raddr (raddr),
      .rdata (at_rdata)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;
   assign clearing   = (state_ff == BK_CLEAR);

endmodule

// File: rtl/text_console_screen_buffer_top.sv
// Text console screen buffer: ROWS x COLUMNS cells of character + attribute.
// A word passes the front stage and the queue, then the back end's result register;
// an on-screen read also passes BK_READ. Each scroll runs a row copy through the
// single store port (BK_COPY), then the bottom-row blank (BK_BLANK).
// Throughput: the back end retires one word a cycle, but an on-screen read or a
// scroll holds it. Reset: synchronous; a clearing pass fills the stores, with busy
// high; the receiver cannot stall results.
module text_console_screen_buffer_top #(
   parameter int COLUMNS  = tcsb_pkg::COLUMNS_DEFAULT,
   parameter int ROWS     = tcsb_pkg::ROWS_DEFAULT,
   parameter int TAB_STOP = tcsb_pkg::TAB_STOP_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        start,
   output logic                        busy,
   input  tcsb_pkg::req_item_type      req_item,
   // result channel
   output logic                        rsp_strobe,
   output tcsb_pkg::rsp_item_type      rsp_item,
   // attribute register
   input  logic                        csr_we,
   input  logic [tcsb_pkg::ATTR_W-1:0] csr_wdata
);
   import tcsb_pkg::*;

   // Attribute written with every printed character.
   logic [ATTR_W-1:0] attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
      end else if (csr_we) begin
         attr_ff <= csr_wdata;
      end
   end

   // Front to queue.
   logic    fe_push;
   cmd_type fe_cmd;
   logic    fe_valid;

   // Queue to back.
   cmd_type q_head;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;

   logic    clearing;

   // Front: take a word whenever its holding stage can drain into the queue;
   // hold off during the clearing pass.
   tcsb_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .hold_off    (clearing),
      .q_full      (q_full),
      .push        (fe_push),
      .cmd         (fe_cmd),
      .stage_valid (fe_valid)
   );

   // Two-entry queue: lets the front keep taking words while a scroll runs.
   tcsb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (fe_push),
      .push_cmd (fe_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   // Back: cursor, stores, scroll sequencer and the result register.
   tcsb_back #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STOP (TAB_STOP)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .char_attr  (attr_ff),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .clearing   (clearing)
   );

   // An accepted word always lands in the front stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> fe_valid)
      else $error("accepted word did not reach the front stage");

   // No result and no dequeue while the stores are being cleared.
   a_quiet_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> (!rsp_strobe && !q_pop))
      else $error("activity during clearing pass");

   // The front must hold off new words during the clearing pass.
   a_busy_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> busy)
      else $error("busy low during clearing pass");

endmodule

// File: verif/tb_text_console_screen_buffer_top.sv
`timescale 1ns / 1ps
// Self-checking bench for text_console_screen_buffer_top: put and read words go in,
// a local mirror of the screen predicts each response word. Needs tcsb_pkg and the RTL.
module tb_text_console_screen_buffer_top;
   import tcsb_pkg::*;

   localparam int SCR_COLS    = COLUMNS_DEFAULT;
   localparam int SCR_ROWS    = ROWS_DEFAULT;
   localparam int SCR_TAB     = TAB_STOP_DEFAULT;
   localparam int SCR_CELLS   = SCR_COLS * SCR_ROWS;
   localparam int REQ_W       = $bits(req_item_type);
   // Slack after the last response, before waiting for busy to fall.
   localparam int SETTLE_CYCLES = 12;
   // Guard on the drain wait; allow room for many scrolls while draining.
   localparam int DRAIN_LIMIT   = 200000;
   localparam int PRINT_CAP     = 40;
   localparam int PHASE_WORDS   = 325;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   req_item_type      req_item;
   logic              rsp_strobe;
   rsp_item_type      rsp_item;
   logic              csr_we;
   logic [ATTR_W-1:0] csr_wdata;

   // Mirror of the screen: cells, cursor and the attribute register.
   logic [CHAR_W-1:0] shadow_char [SCR_CELLS];
   logic [ATTR_W-1:0] shadow_attr [SCR_CELLS];
   int                cursor_x;
   int                cursor_y;
   logic [ATTR_W-1:0] print_attr;

   // Response words still owed by the block, oldest first.
   rsp_item_type      owed_rsp [$];
   rsp_item_type      oldest_rsp;

   int mismatches;
   int words_sent;
   int reads_sent;
   int scroll_count;
   int rsp_checked;
   int sender_idle_pct;

   text_console_screen_buffer_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // 20 ns clock, low first.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Hard stop far beyond the slowest legal run.
   initial begin
      #300_000_000;
      $display("run timed out with %0d response words owed", owed_rsp.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------
   // Screen mirror
   // ---------------------------------------------------------------

   // Restore the power-on screen: spaces, attribute zero, cursor home.
   function automatic void clear_screen();
      for (int i = 0; i < SCR_CELLS; i++) begin
         shadow_char[i] = CODE_SPACE;
         shadow_attr[i] = '0;
      end
      cursor_x   = 0;
      cursor_y   = 0;
      print_attr = ATTR_RESET;
   endfunction

   // Move rows up by one; blank the bottom characters but keep its attributes.
   function automatic void shift_screen_up();
      for (int i = 0; i < (SCR_ROWS - 1) * SCR_COLS; i++) begin
         shadow_char[i] = shadow_char[i + SCR_COLS];
         shadow_attr[i] = shadow_attr[i + SCR_COLS];
      end
      for (int i = (SCR_ROWS - 1) * SCR_COLS; i < SCR_CELLS; i++)
         shadow_char[i] = CODE_SPACE;
      scroll_count++;
   endfunction

   // Wrap an overflowing column into later rows, then scroll off excess rows.
   function automatic void move_cursor(input int x, input int y);
      while (x >= SCR_COLS) begin
         x -= SCR_COLS;
         y++;
      end
      while (y >= SCR_ROWS) begin
         shift_screen_up();
         y--;
      end
      cursor_x = x;
      cursor_y = y;
   endfunction

   // Apply one accepted word to the mirror and return the response it owes.
   function automatic rsp_item_type screen_step(input req_item_type w);
      rsp_item_type r;
      int           row;
      int           col;
      r   = '0;
      row = int'(w.read_row);
      col = int'(w.read_col);
      if (w.operation == OP_READ) begin
         // off-screen reads leave both cell fields at zero
         if (row < SCR_ROWS && col < SCR_COLS) begin
            r.cell_char = shadow_char[row * SCR_COLS + col];
            r.cell_attr = shadow_attr[row * SCR_COLS + col];
         end
      end else if (w.char_code == CODE_CR) begin
         move_cursor(0, cursor_y);
      end else if (w.char_code == CODE_LF) begin
         move_cursor(0, cursor_y + 1);
      end else if (w.char_code == CODE_TAB) begin
         // the extra +1 skips a stop that lies one column ahead
         move_cursor(((cursor_x + 1) / SCR_TAB + 1) * SCR_TAB, cursor_y);
      end else begin
         shadow_char[cursor_y * SCR_COLS + cursor_x] = w.char_code;
         shadow_attr[cursor_y * SCR_COLS + cursor_x] = print_attr;
         move_cursor(cursor_x + 1, cursor_y);
      end
      r.cursor_col = COL_W'(cursor_x);
      r.cursor_row = ROW_W'(cursor_y);
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Word builders
   // ---------------------------------------------------------------

   // Put word; the unused read fields carry noise.
   function automatic req_item_type put_word(input logic [CHAR_W-1:0] code);
      req_item_type w;
      w.operation = OP_PUT;
      w.char_code = code;
      w.read_row  = ROW_W'($urandom);
      w.read_col  = COL_W'($urandom);
      return w;
   endfunction

   // Read word; the unused character field carries noise.
   function automatic req_item_type read_word(input int row, input int col);
      req_item_type w;
      w.operation = OP_READ;
      w.char_code = CHAR_W'($urandom);
      w.read_row  = ROW_W'(row);
      w.read_col  = COL_W'(col);
      return w;
   endfunction

   // Any byte that prints, i.e. not one of the three control codes.
   function automatic logic [CHAR_W-1:0] plain_char();
      logic [CHAR_W-1:0] c;
      c = CHAR_W'($urandom_range(0, 255));
      while (c == CODE_CR || c == CODE_LF || c == CODE_TAB)
         c = CHAR_W'($urandom_range(0, 255));
      return c;
   endfunction

   // ---------------------------------------------------------------
   // Handshake and checking
   // ---------------------------------------------------------------

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   // Send one word. Call at a rising edge; returns at the edge that accepts it.
   // start stays high on return so back-to-back words need no extra edge.
   task automatic send_word(input req_item_type w);
      // drop start for a random run of idle cycles
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= w;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      // accepted at this edge: predict now so the order of expectations is kept
      owed_rsp.push_back(screen_step(w));
      words_sent++;
      if (w.operation == OP_READ)
         reads_sent++;
   endtask

   // Drain all owed responses, give the back end some slack, then wait for !busy.
   task automatic wait_quiet();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (owed_rsp.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (owed_rsp.size() != 0) begin
         $display("%0d response words never arrived", owed_rsp.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         repeat (SETTLE_CYCLES) @(posedge clock);
         while (busy)
            @(posedge clock);
      end
   endtask

   // Write the attribute register while the block is idle.
   task automatic write_attribute(input logic [ATTR_W-1:0] value);
      wait_quiet();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we     <= 1'b0;
      print_attr  = value;
      @(posedge clock);
   endtask

   // Compare each response word with the oldest expectation, field by field.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         rsp_checked++;
         if (owed_rsp.size() == 0) begin
            report_mismatch("response word with nothing owed", int'(rsp_item), 0);
         end else begin
            oldest_rsp = owed_rsp.pop_front();
            if (rsp_item.cell_char !== oldest_rsp.cell_char)
               report_mismatch("cell_char", int'(rsp_item.cell_char),
                               int'(oldest_rsp.cell_char));
            if (rsp_item.cell_attr !== oldest_rsp.cell_attr)
               report_mismatch("cell_attr", int'(rsp_item.cell_attr),
                               int'(oldest_rsp.cell_attr));
            if (rsp_item.cursor_col !== oldest_rsp.cursor_col)
               report_mismatch("cursor_col", int'(rsp_item.cursor_col),
                               int'(oldest_rsp.cursor_col));
            if (rsp_item.cursor_row !== oldest_rsp.cursor_row)
               report_mismatch("cursor_row", int'(rsp_item.cursor_row),
                               int'(oldest_rsp.cursor_row));
         end
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Corners of the freshly cleared screen must read as space, attribute zero.
   task automatic test_power_on_screen();
      send_word(read_word(0, 0));
      send_word(read_word(SCR_ROWS - 1, SCR_COLS - 1));
      send_word(read_word(0, SCR_COLS - 1));
      send_word(read_word(SCR_ROWS - 1, 0));
   endtask

   // Rows and columns past the screen edge, up to the field maximums, read as zero.
   task automatic test_off_screen_reads();
      send_word(read_word(SCR_ROWS, 0));
      send_word(read_word((1 << ROW_W) - 1, (1 << COL_W) - 1));
      send_word(read_word(0, SCR_COLS));
   endtask

   // Extreme bytes, an attribute change, a tab that skips the near stop, CR and LF.
   task automatic test_print_and_controls();
      send_word(put_word(8'h00));
      send_word(put_word(8'hff));
      send_word(put_word(8'h41));
      write_attribute(8'h5a);
      send_word(put_word(8'h61));
      send_word(put_word(8'h62));
      send_word(put_word(8'h63));
      send_word(put_word(8'h64));
      // cursor at column 7: the stop at 8 is skipped, cursor lands on 16
      send_word(put_word(CODE_TAB));
      send_word(put_word(CODE_CR));
      send_word(put_word(CODE_LF));
      // read back across the attribute change and the skipped tab gap
      send_word(read_word(0, 0));
      send_word(read_word(0, 1));
      send_word(read_word(0, 6));
      send_word(read_word(0, 16));
   endtask

   // One random phrase: mostly text runs, tab runs and reads anywhere or by the cursor,
   // with line feeds to push the cursor down and scroll, plus raw noise words.
   task automatic send_random_phrase();
      int               pick;
      int               count;
      int               ending;
      logic [REQ_W-1:0] raw;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         count = $urandom_range(1, 40);
         repeat (count) send_word(put_word(plain_char()));
         ending = $urandom_range(0, 99);
         if (ending < 25) begin
            send_word(put_word(CODE_CR));
            send_word(put_word(CODE_LF));
         end else if (ending < 40) begin
            send_word(put_word(CODE_LF));
         end else if (ending < 50) begin
            send_word(put_word(CODE_CR));
         end
      end else if (pick < 60) begin
         // long enough tab runs cross the right edge and wrap, or scroll at the bottom
         count = $urandom_range(1, 12);
         repeat (count) begin
            if ($urandom_range(0, 99) < 30)
               send_word(put_word(plain_char()));
            send_word(put_word(CODE_TAB));
         end
      end else if (pick < 85) begin
         count = $urandom_range(1, 6);
         repeat (count) begin
            ending = $urandom_range(0, 99);
            if (ending < 60)
               send_word(read_word($urandom_range(0, SCR_ROWS - 1),
                                   $urandom_range(0, SCR_COLS - 1)));
            else if (ending < 85)
               // just behind the cursor: the cell most recently printed
               send_word(read_word(cursor_y, (cursor_x > 0) ? cursor_x - 1 : 0));
            else
               send_word(read_word($urandom_range(0, (1 << ROW_W) - 1),
                                   $urandom_range(0, (1 << COL_W) - 1)));
         end
      end else if (pick < 92) begin
         count = $urandom_range(1, 3);
         repeat (count) send_word(put_word(CODE_LF));
      end else begin
         raw = REQ_W'($urandom);
         send_word(raw);
      end
   endtask

   // One phase of random traffic under one attribute and one idle rate.
   task automatic run_random_phase(input int idle_pct, input logic [ATTR_W-1:0] attr);
      int first_word;
      write_attribute(attr);
      sender_idle_pct = idle_pct;
      first_word      = words_sent;
      while (words_sent - first_word < PHASE_WORDS)
         send_random_phrase();
      sender_idle_pct = 0;
   endtask

   // Random traffic through the attribute extremes and the idle settings.
   task automatic test_random_traffic();
      run_random_phase(0, 8'hff);
      run_random_phase(67, 8'h00);
      run_random_phase(10, ATTR_W'($urandom));
      run_random_phase(0, ATTR_W'($urandom));
   endtask

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_item        = '0;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      mismatches      = 0;
      words_sent      = 0;
      reads_sent      = 0;
      scroll_count    = 0;
      rsp_checked     = 0;
      sender_idle_pct = 0;
      clear_screen();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // the first word waits out the clearing pass through busy
      test_power_on_screen();
      test_off_screen_reads();
      test_print_and_controls();
      test_random_traffic();

      wait_quiet();
      $display("covered %0d words (%0d cell reads), %0d screen scrolls, %0d responses checked",
               words_sent, reads_sent, scroll_count, rsp_checked);
      if (mismatches == 0 && owed_rsp.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
